// ----- rtl/mmio_dec_pkg.sv -----
// Shared types, opcode constants and size rules for the MOV/MOVZX instruction decoder.
// Has no dependencies; imported by rtl/mmio_mov_instruction_decoder.sv.
`default_nettype none

package mmio_dec_pkg;

  // Longest instruction and longest prefix/opcode span in bytes.
  localparam int unsigned MAX_LENGTH      = 15;
  localparam int unsigned MAX_PREFIX_SPAN = 13;

  localparam logic [7:0] OP_PFX_OPSIZE = 8'h66;
  localparam logic [7:0] OP_PFX_FS     = 8'h64;
  localparam logic [7:0] OP_PFX_GS     = 8'h65;
  localparam logic [7:0] OP_PFX_ADSIZE = 8'h67;
  localparam logic [7:0] OP_REX_LO     = 8'h40;
  localparam logic [7:0] OP_REX_HI     = 8'h4F;
  localparam logic [7:0] OP_ESCAPE     = 8'h0F;
  localparam logic [7:0] OP_MOV_ST8    = 8'h88;
  localparam logic [7:0] OP_MOV_ST     = 8'h89;
  localparam logic [7:0] OP_MOV_LD8    = 8'h8A;
  localparam logic [7:0] OP_MOVZX8     = 8'hB6;
  localparam logic [7:0] OP_MOVZX16    = 8'hB7;
  localparam logic [7:0] OP_MOV_IMM    = 8'hC7;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_PREFIX   = 2'd1,
    ERR_HIGHBYTE = 2'd2,
    ERR_LENGTH   = 2'd3
  } err_e;

  // Declared from the highest field down so that access_size lands in the lowest bits.
  typedef struct packed {
    err_e        error_code;
    logic [3:0]  instr_length;
    logic [3:0]  reg_write_size;
    logic [3:0]  reg_index;
    logic [31:0] imm_value;
    logic        from_immediate;
    logic        is_write;
    logic [3:0]  access_size;
  } result_t;

  function automatic logic [3:0] op_size(input logic operand_16);
    return operand_16 ? 4'd2 : 4'd4;
  endfunction

  function automatic logic [3:0] access_bytes(input logic [7:0] opcode,
                                              input logic       rex_w,
                                              input logic       operand_16);
    logic [3:0] size;
    case (opcode)
      OP_MOV_ST8, OP_MOV_LD8, OP_MOVZX8: size = 4'd1;
      OP_MOVZX16:                         size = 4'd2;
      default:                            size = rex_w ? 4'd8 : op_size(operand_16);
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mmio_mov_instruction_decoder.sv -----
// Byte-serial decoder for faulting MOV/MOVZX memory instructions, one result per instruction.
// Depends on rtl/mmio_dec_pkg.sv for constants, the result layout and the size rules.
//
//   Channel   Direction  tdata / tuser contents
//   s_axis    in         tdata[7:0] instr_byte; tuser start_req
//   m_axis    out        tdata[55:0] decode result (see port comment)
//
// Every byte is decoded in the cycle it is accepted: one byte per clock while not stalled.
// The result of the final byte appears in the output register on the next cycle.
// The output register acts as the only stage between the sides: a new byte is taken
// whenever it is empty or is being drained, and a stall holds the result and the input.
// Reset clears the decode state to idle and empties the output register.
`default_nettype none

module mmio_mov_instruction_decoder #(
  parameter int unsigned MAX_LENGTH      = mmio_dec_pkg::MAX_LENGTH,
  parameter int unsigned MAX_PREFIX_SPAN = mmio_dec_pkg::MAX_PREFIX_SPAN
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] instr_byte
  input  wire logic        s_axis_tuser,   // [0] start_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] access_size, [4] is_write, [5] from_immediate, [37:6] imm_value,
  // [41:38] reg_index, [45:42] reg_write_size, [49:46] instr_length,
  // [51:50] error_code, [55:52] zero
  output logic [55:0]      m_axis_tdata
);
  import mmio_dec_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PREFIX, PH_ESC, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        op16_q, op16_d;
  logic [3:0]  rex_q, rex_d;
  logic        rex_seen_q, rex_seen_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [3:0]  count_q, count_d;
  logic [2:0]  skip_q, skip_d;
  logic [2:0]  imm_left_q, imm_left_d;
  logic [31:0] imm_acc_q, imm_acc_d;
  logic [1:0]  mod_q, mod_d;
  logic [2:0]  reg_q, reg_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic        in_accept;
  logic [7:0]  in_byte;
  logic [4:0]  count_inc;
  logic        after_addr;
  logic        emit_ok;
  logic        emit_err;
  err_e        err_code;
  logic [3:0]  err_len;
  logic [3:0]  size_now;
  logic [3:0]  rws;
  logic [1:0]  lane;
  logic        is_wr;
  logic        is_imm;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_byte       = s_axis_tdata;

  always_comb begin
    // A start mark drops whatever was in progress and begins from a clean state.
    if (s_axis_tuser) begin
      phase_d    = PH_PREFIX;
      op16_d     = 1'b0;
      rex_d      = '0;
      rex_seen_d = 1'b0;
      opcode_d   = '0;
      count_d    = '0;
      skip_d     = '0;
      imm_left_d = '0;
      imm_acc_d  = '0;
      mod_d      = '0;
      reg_d      = '0;
    end else begin
      phase_d    = phase_q;
      op16_d     = op16_q;
      rex_d      = rex_q;
      rex_seen_d = rex_seen_q;
      opcode_d   = opcode_q;
      count_d    = count_q;
      skip_d     = skip_q;
      imm_left_d = imm_left_q;
      imm_acc_d  = imm_acc_q;
      mod_d      = mod_q;
      reg_d      = reg_q;
    end

    count_inc  = {1'b0, count_d} + 5'd1;
    after_addr = 1'b0;
    emit_ok    = 1'b0;
    emit_err   = 1'b0;
    err_code   = ERR_NONE;
    err_len    = '0;
    lane       = '0;

    if (!in_accept || (!s_axis_tuser && phase_q == PH_IDLE)) begin
      // Nothing taken, or a stray byte while idle: state stays as it is.
      phase_d    = phase_q;
      op16_d     = op16_q;
      rex_d      = rex_q;
      rex_seen_d = rex_seen_q;
      opcode_d   = opcode_q;
      count_d    = count_q;
      skip_d     = skip_q;
      imm_left_d = imm_left_q;
      imm_acc_d  = imm_acc_q;
      mod_d      = mod_q;
      reg_d      = reg_q;
    end else if (count_inc > 5'(MAX_LENGTH)) begin
      emit_err = 1'b1;
      err_code = ERR_LENGTH;
    end else begin
      count_d = count_inc[3:0];
      case (phase_d)
        PH_PREFIX: begin
          if (count_inc > 5'(MAX_PREFIX_SPAN)) begin
            emit_err = 1'b1;
            err_code = ERR_PREFIX;
            err_len  = count_inc[3:0];
          end else if (in_byte == OP_PFX_OPSIZE) begin
            op16_d = 1'b1;
          end else if (in_byte == OP_PFX_FS || in_byte == OP_PFX_GS ||
                       in_byte == OP_PFX_ADSIZE) begin
            phase_d = PH_PREFIX;
          end else if (in_byte >= OP_REX_LO && in_byte <= OP_REX_HI) begin
            rex_seen_d = 1'b1;
            rex_d      = in_byte[3:0];
          end else if (in_byte == OP_ESCAPE) begin
            phase_d = PH_ESC;
          end else begin
            opcode_d = in_byte;
            phase_d  = PH_MODRM;
          end
        end
        PH_ESC: begin
          opcode_d = in_byte;
          phase_d  = PH_MODRM;
        end
        PH_MODRM: begin
          mod_d = in_byte[7:6];
          reg_d = in_byte[5:3];
          // Without REX, byte register codes 4..7 are AH..BH and rejected (MOVZX8 excepted).
          if (access_bytes(opcode_d, rex_d[3], op16_d) == 4'd1 && in_byte[5] &&
              !rex_seen_d && opcode_d != OP_MOVZX8) begin
            emit_err = 1'b1;
            err_code = ERR_HIGHBYTE;
            err_len  = count_inc[3:0];
          end else if (in_byte[7:6] != 2'd3 && in_byte[2:0] == 3'd4) begin
            phase_d = PH_SIB;
          end else begin
            if (in_byte[7:6] == 2'd2 || (in_byte[7:6] == 2'd0 && in_byte[2:0] == 3'd5)) begin
              skip_d = 3'd4;
            end else if (in_byte[7:6] == 2'd1) begin
              skip_d = 3'd1;
            end else begin
              skip_d = 3'd0;
            end
            after_addr = 1'b1;
          end
        end
        PH_SIB: begin
          if (mod_d == 2'd2 || (mod_d == 2'd0 && in_byte[2:0] == 3'd5)) begin
            skip_d = 3'd4;
          end else if (mod_d == 2'd1) begin
            skip_d = 3'd1;
          end else begin
            skip_d = 3'd0;
          end
          after_addr = 1'b1;
        end
        PH_DISP: begin
          if (skip_d != 3'd0) begin
            skip_d = skip_d - 3'd1;
          end
          if (skip_d == 3'd0) begin
            after_addr = 1'b1;
          end
        end
        PH_IMM: begin
          lane = 2'(op_size(op16_d) - {1'b0, imm_left_d});
          case (lane)
            2'd0:    imm_acc_d[7:0]   = imm_acc_d[7:0]   | in_byte;
            2'd1:    imm_acc_d[15:8]  = imm_acc_d[15:8]  | in_byte;
            2'd2:    imm_acc_d[23:16] = imm_acc_d[23:16] | in_byte;
            default: imm_acc_d[31:24] = imm_acc_d[31:24] | in_byte;
          endcase
          if (imm_left_d != 3'd0) begin
            imm_left_d = imm_left_d - 3'd1;
          end
          if (imm_left_d == 3'd0) begin
            emit_ok = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      // Address bytes done: displacement next, then the immediate of C7, else finished.
      if (after_addr) begin
        if (skip_d != 3'd0) begin
          phase_d = PH_DISP;
        end else if (opcode_d == OP_MOV_IMM) begin
          imm_left_d = 3'(op_size(op16_d));
          imm_acc_d  = '0;
          phase_d    = PH_IMM;
        end else begin
          emit_ok = 1'b1;
        end
      end
    end

    size_now = access_bytes(opcode_d, rex_d[3], op16_d);
    is_wr    = (opcode_d == OP_MOV_ST8 || opcode_d == OP_MOV_ST || opcode_d == OP_MOV_IMM);
    is_imm   = (opcode_d == OP_MOV_IMM);
    if (is_wr) begin
      rws = '0;
    end else if (opcode_d == OP_MOVZX8) begin
      rws = rex_d[3] ? 4'd8 : op_size(op16_d);
    end else if (opcode_d == OP_MOVZX16) begin
      rws = 4'd8;
    end else begin
      rws = (size_now == 4'd4) ? 4'd8 : size_now;
    end

    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (emit_err) begin
      out_d              = '0;
      out_d.error_code   = err_code;
      out_d.instr_length = err_len;
      out_valid_d        = 1'b1;
      phase_d            = PH_IDLE;
    end else if (emit_ok) begin
      out_d.access_size    = size_now;
      out_d.is_write       = is_wr;
      out_d.from_immediate = is_imm;
      out_d.imm_value      = is_imm ? imm_acc_d : '0;
      out_d.reg_index      = {rex_d[2], reg_d};
      out_d.reg_write_size = rws;
      out_d.instr_length   = count_d;
      out_d.error_code     = ERR_NONE;
      out_valid_d          = 1'b1;
      phase_d              = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      op16_q      <= 1'b0;
      rex_q       <= '0;
      rex_seen_q  <= 1'b0;
      opcode_q    <= '0;
      count_q     <= '0;
      skip_q      <= '0;
      imm_left_q  <= '0;
      imm_acc_q   <= '0;
      mod_q       <= '0;
      reg_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      op16_q      <= op16_d;
      rex_q       <= rex_d;
      rex_seen_q  <= rex_seen_d;
      opcode_q    <= opcode_d;
      count_q     <= count_d;
      skip_q      <= skip_d;
      imm_left_q  <= imm_left_d;
      imm_acc_q   <= imm_acc_d;
      mod_q       <= mod_d;
      reg_q       <= reg_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

`ifndef SYNTHESIS
  // An error result carries nothing but its code and length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.error_code != ERR_NONE |->
      out_q.access_size == 4'd0 && !out_q.is_write && out_q.imm_value == 32'd0)
    else $error("error result carries decode fields");

  // A good result has a real length and a legal access size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.error_code == ERR_NONE |->
      out_q.instr_length != 4'd0 &&
      (out_q.access_size == 4'd1 || out_q.access_size == 4'd2 ||
       out_q.access_size == 4'd4 || out_q.access_size == 4'd8))
    else $error("good result with bad length or size");

  // Input is only held off by a result that is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending result");

  // A stalled result must not be overwritten by the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_q))
    else $error("pending result changed while stalled");
`endif

endmodule

`default_nettype wire
